/* hdl/rect_atlas_allocator_assert.svh */
// Assertion macros for the rectangle atlas allocator
`ifndef RECT_ATLAS_ALLOCATOR_ASSERT_SVH
`define RECT_ATLAS_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define RAA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RAA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RAA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/raa_pkg.sv */
// Shared types and constants of the rectangle atlas allocator
package raa_pkg;

  localparam int FIELD_BITS     = 13;
  localparam int CFG_IDX_BITS   = 3;
  localparam int MAX_FREE_DEF   = 64;
  localparam int COORD_BITS_DEF = 13;

  localparam logic [FIELD_BITS-1:0] START_W_RST = 13'd256;
  localparam logic [FIELD_BITS-1:0] START_H_RST = 13'd256;
  localparam logic [FIELD_BITS-1:0] LIMIT_W_RST = 13'd1024;
  localparam logic [FIELD_BITS-1:0] LIMIT_H_RST = 13'd1024;

  localparam logic [CFG_IDX_BITS-1:0] CFG_START_W = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_H = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_W = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_H = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAST    = 3'd4;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [FIELD_BITS-1:0] req_width;
    logic [FIELD_BITS-1:0] req_height;
  } in_t;

  typedef struct packed {
    logic                  granted;
    logic [FIELD_BITS-1:0] pos_x;
    logic [FIELD_BITS-1:0] pos_y;
    logic [FIELD_BITS-1:0] atlas_width;
    logic [FIELD_BITS-1:0] atlas_height;
    logic                  list_overflow;
  } out_t;

  typedef struct packed {
    logic fits;
    logic overlap;
    logic a_in_b;
    logic b_in_a;
  } geom_flags_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_RS_WR,
    ST_FB_RD, ST_FB_MUL, ST_FB_CMP, ST_FB_END,
    ST_GR_RD, ST_GR_DO,
    ST_FAST_WR, ST_FAST_PUSH,
    ST_SP_CHK, ST_SP_TEST, ST_SP_PUSH,
    ST_RC_OUTER, ST_RC_INNER, ST_RC_CHK,
    ST_ER_CHK, ST_ER_WR,
    ST_DONE
  } state_t;

endpackage

/* hdl/raa_ram.sv */
// Generic RAM: one write port, two registered read ports
module raa_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hdl/raa_geom.sv */
// Shared geometry unit: fit, overlap, containment and registered area
module raa_geom #(
  parameter int COORD_BITS = raa_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic [4*COORD_BITS-1:0]            a_rect,
  input  logic [4*COORD_BITS-1:0]            b_rect,
  input  logic [raa_pkg::FIELD_BITS-1:0]     req_width,
  input  logic [raa_pkg::FIELD_BITS-1:0]     req_height,
  output raa_pkg::geom_flags_t               flags,
  output logic [2*COORD_BITS-1:0]            area
);

  localparam int CB = COORD_BITS;
  localparam int XW = (CB > raa_pkg::FIELD_BITS) ? CB : raa_pkg::FIELD_BITS;

  logic [CB-1:0] al, at, ar, ab, bl, bt, br, bb, fw, fh;

  assign al = a_rect[4*CB-1:3*CB];
  assign at = a_rect[3*CB-1:2*CB];
  assign ar = a_rect[2*CB-1:CB];
  assign ab = a_rect[CB-1:0];
  assign bl = b_rect[4*CB-1:3*CB];
  assign bt = b_rect[3*CB-1:2*CB];
  assign br = b_rect[2*CB-1:CB];
  assign bb = b_rect[CB-1:0];

  assign fw = ar - al;
  assign fh = ab - at;

  always_comb begin
    flags.fits    = (XW'(fw) >= XW'(req_width)) && (XW'(fh) >= XW'(req_height));
    // b is the placed rectangle in the split test; strict overlap on both axes
    flags.overlap = (br > al) && (bl < ar) && (bb > at) && (bt < ab);
    flags.a_in_b  = (al >= bl) && (at >= bt) && (ar <= br) && (ab <= bb);
    flags.b_in_a  = (bl >= al) && (bt >= at) && (br <= ar) && (bb <= ab);
  end

  always_ff @(posedge clk) begin
    area <= fw * fh;
  end

endmodule

/* hdl/rect_atlas_allocator.sv */
// Rectangle atlas allocator: best-area-fit max-rects packer, sequenced over one RAM.
// Restart rewrites the free list to the start area. Allocate searches all free entries,
// grows the atlas while nothing fits, then applies the fast guillotine split or a full
// split pass with erases of split entries and a containment pass over entry pairs.
// One transaction at a time; the free-list RAM port and the sequencer set the rate.
// Synchronous reset; state INIT then writes the initial free area, then ready.
`include "rect_atlas_allocator_assert.svh"
module rect_atlas_allocator #(
  parameter int MAX_FREE   = raa_pkg::MAX_FREE_DEF,
  parameter int COORD_BITS = raa_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  raa_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output raa_pkg::out_t                    out_data,
  input  logic                             cfg_wr_en,
  input  logic [raa_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [raa_pkg::FIELD_BITS-1:0]   cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int FB   = raa_pkg::FIELD_BITS;
  localparam int XW   = (CB > FB) ? CB : FB;
  localparam int RW   = 4 * CB;
  localparam int IDX  = $clog2(MAX_FREE);
  localparam int CNT  = $clog2(MAX_FREE + 1);
  localparam logic [CB-1:0]  COORD_MAX = '1;
  localparam logic [CNT-1:0] CNT_MAX   = CNT'(MAX_FREE);
  localparam logic [CNT-1:0] CNT_ONE   = CNT'(1);

  function automatic logic [CB-1:0] f_l(input logic [RW-1:0] x);
    return x[4*CB-1:3*CB];
  endfunction
  function automatic logic [CB-1:0] f_t(input logic [RW-1:0] x);
    return x[3*CB-1:2*CB];
  endfunction
  function automatic logic [CB-1:0] f_r(input logic [RW-1:0] x);
    return x[2*CB-1:CB];
  endfunction
  function automatic logic [CB-1:0] f_b(input logic [RW-1:0] x);
    return x[CB-1:0];
  endfunction
  function automatic logic [CB-1:0] clamp_sz(input logic [FB-1:0] v);
    logic [XW-1:0] ve;
    ve = XW'(v);
    return (ve > XW'(COORD_MAX)) ? COORD_MAX : ve[CB-1:0];
  endfunction

  raa_pkg::state_t state, state_next, ret_st;

  logic [FB-1:0]    start_w, start_h, limit_w, limit_h;
  logic             fast;
  logic [CNT-1:0]   count, i, j, ek;
  logic [1:0]       piece;
  logic [CB-1:0]    cur_w, cur_h;
  logic             grow_w, ovf;
  logic [FB-1:0]    req_w, req_h;
  logic             found, cand_fit;
  logic [2*CB-1:0]  best_area;
  logic [IDX-1:0]   best_idx;
  logic [RW-1:0]    best_rect, cand_rect, placed, e_rect;
  logic             res_granted;
  logic [CB-1:0]    res_x, res_y;

  logic [RW-1:0]    rd_a, rd_b, geom_b;
  logic [IDX-1:0]   rd_addr_a, rd_addr_b, wr_addr;
  logic             wr_en, push_en, push_ok;
  logic [RW-1:0]    wr_data, push_rect;
  raa_pkg::geom_flags_t flags;
  logic [2*CB-1:0]  area_q;

  logic             accept, out_load;
  logic [CB-1:0]    g_old, g_nv;
  logic [FB-1:0]    g_lim;
  logic [CB:0]      g_dbl;
  logic             g_fail, g_single;
  logic [CB-1:0]    fh_best;
  logic             fast_cut;

  assign in_ready = (state == raa_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == raa_pkg::ST_DONE) && (!out_valid || out_ready);
  assign push_ok  = count < CNT_MAX;
  assign geom_b   = (state == raa_pkg::ST_RC_CHK) ? rd_b : placed;

  // growth step
  assign g_old    = grow_w ? cur_w : cur_h;
  assign g_lim    = grow_w ? limit_w : limit_h;
  assign g_dbl    = {g_old, 1'b0};
  assign g_nv     = (g_dbl > (CB+1)'(COORD_MAX)) ? COORD_MAX : g_dbl[CB-1:0];
  assign g_fail   = (XW'(g_old) >= XW'(g_lim)) || (g_nv == g_old);
  assign g_single = (count == CNT_ONE) && (f_l(rd_a) == '0) && (f_t(rd_a) == '0) &&
                    (grow_w ? (f_r(rd_a) == g_old && f_b(rd_a) == cur_h)
                            : (f_r(rd_a) == cur_w && f_b(rd_a) == g_old));

  // guillotine split decision
  assign fh_best  = f_b(best_rect) - f_t(best_rect);
  assign fast_cut = ((XW+1)'(fh_best) > ((XW+1)'(req_h) << 1)) ||
                    (XW'(req_h) >= XW'(cur_h >> 1));

  raa_ram #(.WIDTH(RW), .DEPTH(MAX_FREE)) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (rd_addr_a),
    .rdata_a (rd_a),
    .raddr_b (rd_addr_b),
    .rdata_b (rd_b)
  );

  raa_geom #(.COORD_BITS(CB)) u_geom (
    .clk        (clk),
    .a_rect     (rd_a),
    .b_rect     (geom_b),
    .req_width  (req_w),
    .req_height (req_h),
    .flags      (flags),
    .area       (area_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      raa_pkg::ST_INIT:      state_next = raa_pkg::ST_IDLE;
      raa_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (in_data.kind == raa_pkg::KIND_RESTART) ? raa_pkg::ST_RS_WR
                                                               : raa_pkg::ST_FB_RD;
        end
      end
      raa_pkg::ST_RS_WR:     state_next = raa_pkg::ST_DONE;
      raa_pkg::ST_FB_RD:     state_next = (i < count) ? raa_pkg::ST_FB_MUL
                                                      : raa_pkg::ST_FB_END;
      raa_pkg::ST_FB_MUL:    state_next = raa_pkg::ST_FB_CMP;
      raa_pkg::ST_FB_CMP:    state_next = raa_pkg::ST_FB_RD;
      raa_pkg::ST_FB_END: begin
        if (!found)    state_next = raa_pkg::ST_GR_RD;
        else if (fast) state_next = raa_pkg::ST_FAST_WR;
        else           state_next = raa_pkg::ST_SP_CHK;
      end
      raa_pkg::ST_GR_RD:     state_next = raa_pkg::ST_GR_DO;
      raa_pkg::ST_GR_DO:     state_next = g_fail ? raa_pkg::ST_DONE : raa_pkg::ST_FB_RD;
      raa_pkg::ST_FAST_WR:   state_next = raa_pkg::ST_FAST_PUSH;
      raa_pkg::ST_FAST_PUSH: state_next = raa_pkg::ST_DONE;
      raa_pkg::ST_SP_CHK:    state_next = (i < count) ? raa_pkg::ST_SP_TEST
                                                      : raa_pkg::ST_RC_OUTER;
      raa_pkg::ST_SP_TEST:   state_next = flags.overlap ? raa_pkg::ST_SP_PUSH
                                                        : raa_pkg::ST_SP_CHK;
      raa_pkg::ST_SP_PUSH:   state_next = (piece == 2'd3) ? raa_pkg::ST_ER_CHK
                                                          : raa_pkg::ST_SP_PUSH;
      raa_pkg::ST_RC_OUTER:  state_next = (i < count) ? raa_pkg::ST_RC_INNER
                                                      : raa_pkg::ST_DONE;
      raa_pkg::ST_RC_INNER:  state_next = (j < count) ? raa_pkg::ST_RC_CHK
                                                      : raa_pkg::ST_RC_OUTER;
      raa_pkg::ST_RC_CHK: begin
        if (flags.a_in_b || flags.b_in_a) state_next = raa_pkg::ST_ER_CHK;
        else                              state_next = raa_pkg::ST_RC_INNER;
      end
      raa_pkg::ST_ER_CHK:    state_next = ((ek + CNT_ONE) < count) ? raa_pkg::ST_ER_WR
                                                                   : ret_st;
      raa_pkg::ST_ER_WR:     state_next = raa_pkg::ST_ER_CHK;
      raa_pkg::ST_DONE:      state_next = out_load ? raa_pkg::ST_IDLE : raa_pkg::ST_DONE;
      default:               state_next = raa_pkg::ST_IDLE;
    endcase
  end

  // memory and push controls
  always_comb begin
    rd_addr_a = i[IDX-1:0];
    rd_addr_b = j[IDX-1:0];
    push_en   = 1'b0;
    push_rect = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    unique case (state)
      raa_pkg::ST_INIT, raa_pkg::ST_RS_WR: begin
        wr_en   = 1'b1;
        wr_data = {CB'(0), CB'(0), cur_w, cur_h};
      end
      raa_pkg::ST_GR_RD: rd_addr_a = '0;
      raa_pkg::ST_GR_DO: begin
        if (!g_fail) begin
          if (g_single) begin
            wr_en   = 1'b1;
            wr_data = grow_w ? {CB'(0), CB'(0), g_nv, cur_h}
                             : {CB'(0), CB'(0), cur_w, g_nv};
          end else begin
            push_en   = 1'b1;
            push_rect = grow_w ? {g_old, CB'(0), g_nv, cur_h}
                               : {CB'(0), g_old, cur_w, g_nv};
          end
        end
      end
      raa_pkg::ST_FAST_WR: begin
        wr_en   = 1'b1;
        wr_addr = best_idx;
        wr_data = {f_r(placed), f_t(best_rect), f_r(best_rect),
                   fast_cut ? f_b(placed) : f_b(best_rect)};
      end
      raa_pkg::ST_FAST_PUSH: begin
        push_en   = fast_cut;
        push_rect = {f_l(placed), f_b(placed), f_r(best_rect), f_b(best_rect)};
      end
      raa_pkg::ST_SP_PUSH: begin
        unique case (piece)
          2'd0: begin
            push_en   = f_r(placed) < f_r(e_rect);
            push_rect = {f_r(placed), f_t(e_rect), f_r(e_rect), f_b(e_rect)};
          end
          2'd1: begin
            push_en   = f_l(placed) > f_l(e_rect);
            push_rect = {f_l(e_rect), f_t(e_rect), f_l(placed), f_b(e_rect)};
          end
          2'd2: begin
            push_en   = f_b(placed) < f_b(e_rect);
            push_rect = {f_l(e_rect), f_b(placed), f_r(e_rect), f_b(e_rect)};
          end
          default: begin
            push_en   = f_t(placed) > f_t(e_rect);
            push_rect = {f_l(e_rect), f_t(e_rect), f_r(e_rect), f_t(placed)};
          end
        endcase
      end
      raa_pkg::ST_ER_CHK: rd_addr_a = IDX'(ek + CNT_ONE);
      raa_pkg::ST_ER_WR: begin
        wr_en   = 1'b1;
        wr_addr = ek[IDX-1:0];
        wr_data = rd_a;
      end
      default: ;
    endcase
    if (push_en) begin
      wr_en   = push_ok;
      wr_addr = count[IDX-1:0];
      wr_data = push_rect;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      start_w <= raa_pkg::START_W_RST;
      start_h <= raa_pkg::START_H_RST;
      limit_w <= raa_pkg::LIMIT_W_RST;
      limit_h <= raa_pkg::LIMIT_H_RST;
      fast    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        raa_pkg::CFG_START_W: start_w <= cfg_data;
        raa_pkg::CFG_START_H: start_h <= cfg_data;
        raa_pkg::CFG_LIMIT_W: limit_w <= cfg_data;
        raa_pkg::CFG_LIMIT_H: limit_h <= cfg_data;
        raa_pkg::CFG_FAST:    fast    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= raa_pkg::ST_INIT;
      ret_st    <= raa_pkg::ST_IDLE;
      count     <= CNT_ONE;
      cur_w     <= clamp_sz(raa_pkg::START_W_RST);
      cur_h     <= clamp_sz(raa_pkg::START_H_RST);
      grow_w    <= 1'b1;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      i         <= '0;
      j         <= '0;
      ek        <= '0;
      piece     <= '0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      if (push_en) begin
        if (push_ok) count <= count + CNT_ONE;
        else         ovf   <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        raa_pkg::ST_IDLE: begin
          if (accept) begin
            req_w       <= in_data.req_width;
            req_h       <= in_data.req_height;
            res_granted <= 1'b0;
            res_x       <= '0;
            res_y       <= '0;
            i           <= '0;
            found       <= 1'b0;
            if (in_data.kind == raa_pkg::KIND_RESTART) begin
              cur_w  <= clamp_sz(start_w);
              cur_h  <= clamp_sz(start_h);
              grow_w <= 1'b1;
              ovf    <= 1'b0;
              count  <= CNT_ONE;
            end
          end
        end
        raa_pkg::ST_FB_MUL: begin
          cand_rect <= rd_a;
          cand_fit  <= flags.fits;
        end
        raa_pkg::ST_FB_CMP: begin
          if (cand_fit && (!found || area_q < best_area)) begin
            found     <= 1'b1;
            best_area <= area_q;
            best_rect <= cand_rect;
            best_idx  <= i[IDX-1:0];
          end
          i <= i + CNT_ONE;
        end
        raa_pkg::ST_FB_END: begin
          if (found) begin
            res_granted <= 1'b1;
            res_x       <= f_l(best_rect);
            res_y       <= f_t(best_rect);
            placed      <= {f_l(best_rect), f_t(best_rect),
                            f_l(best_rect) + CB'(req_w), f_t(best_rect) + CB'(req_h)};
            i           <= '0;
          end
        end
        raa_pkg::ST_GR_DO: begin
          if (!g_fail) begin
            if (grow_w) cur_w <= g_nv;
            else        cur_h <= g_nv;
            grow_w <= !grow_w;
            i      <= '0;
            found  <= 1'b0;
          end
        end
        raa_pkg::ST_SP_CHK: begin
          if (i >= count) i <= '0;
        end
        raa_pkg::ST_SP_TEST: begin
          if (flags.overlap) begin
            e_rect <= rd_a;
            piece  <= '0;
          end else begin
            i <= i + CNT_ONE;
          end
        end
        raa_pkg::ST_SP_PUSH: begin
          piece <= piece + 2'd1;
          if (piece == 2'd3) begin
            ek     <= i;
            ret_st <= raa_pkg::ST_SP_CHK;
          end
        end
        raa_pkg::ST_RC_OUTER: begin
          j <= i + CNT_ONE;
        end
        raa_pkg::ST_RC_INNER: begin
          if (j >= count) i <= i + CNT_ONE;
        end
        raa_pkg::ST_RC_CHK: begin
          if (flags.a_in_b) begin
            ek     <= i;
            ret_st <= raa_pkg::ST_RC_OUTER;
          end else if (flags.b_in_a) begin
            ek     <= j;
            ret_st <= raa_pkg::ST_RC_INNER;
          end else begin
            j <= j + CNT_ONE;
          end
        end
        raa_pkg::ST_ER_CHK: begin
          if ((ek + CNT_ONE) >= count) count <= count - CNT_ONE;
        end
        raa_pkg::ST_ER_WR: begin
          ek <= ek + CNT_ONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.granted       <= res_granted;
      out_data.pos_x         <= FB'(res_x);
      out_data.pos_y         <= FB'(res_y);
      out_data.atlas_width   <= FB'(cur_w);
      out_data.atlas_height  <= FB'(cur_h);
      out_data.list_overflow <= ovf;
    end
  end

  `RAA_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_MAX)
  `RAA_ASSERT_NEXT(a_restart_one, clk, rst, accept && in_data.kind == raa_pkg::KIND_RESTART, count == CNT_ONE && !ovf)
  `RAA_ASSERT_IMPL(a_erase_src, clk, rst, state == raa_pkg::ST_ER_WR, (ek + CNT_ONE) < count)

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the rectangle atlas allocator: directed table, then random phases
`timescale 1ns / 100ps
module tb_top;

  localparam int NFREE = raa_pkg::MAX_FREE_DEF;
  localparam int unsigned CMAX = (1 << raa_pkg::COORD_BITS_DEF) - 1;
  localparam int STALL_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int FB = raa_pkg::FIELD_BITS;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  raa_pkg::in_t in_data;
  raa_pkg::out_t out_data;
  logic cfg_wr_en;
  logic [raa_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [FB-1:0] cfg_data;

  rect_atlas_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the block: registers and free-rectangle list
  int unsigned sh_start_w, sh_start_h, sh_lim_w, sh_lim_h;
  bit sh_fast;
  int unsigned fl[NFREE], ft[NFREE], fr[NFREE], fb[NFREE];
  int unsigned nfree, atlas_w, atlas_h;
  bit widen_next, dropped;

  raa_pkg::out_t placements_due[$];
  int errors = 0, n_items = 0, n_restarts = 0, n_granted = 0, n_refused = 0, n_overflow = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_trigger = 0;
  int quiet_cycles = 0;

  function automatic void add_free(int unsigned l, t, r, b);
    if (nfree < NFREE) begin
      fl[nfree] = l; ft[nfree] = t; fr[nfree] = r; fb[nfree] = b;
      nfree++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  function automatic void drop_free(int unsigned i);
    if (i >= nfree) return;
    for (int unsigned k = i; k + 1 < nfree; k++) begin
      fl[k] = fl[k+1]; ft[k] = ft[k+1]; fr[k] = fr[k+1]; fb[k] = fb[k+1];
    end
    nfree--;
  endfunction

  function automatic int unsigned twice(int unsigned v);
    return (v * 2 > CMAX) ? CMAX : v * 2;
  endfunction

  function automatic bit enlarge_atlas();
    int unsigned old, nv;
    bit whole;
    if (widen_next) begin
      if (atlas_w >= sh_lim_w) return 0;
      old = atlas_w;
      nv = twice(old);
      if (nv == old) return 0;
      atlas_w = nv;
      whole = nfree == 1 && fl[0] == 0 && ft[0] == 0 && fr[0] == old && fb[0] == atlas_h;
      if (whole) fr[0] = nv;
      else add_free(old, 0, nv, atlas_h);
    end else begin
      if (atlas_h >= sh_lim_h) return 0;
      old = atlas_h;
      nv = twice(old);
      if (nv == old) return 0;
      atlas_h = nv;
      whole = nfree == 1 && fl[0] == 0 && ft[0] == 0 && fr[0] == atlas_w && fb[0] == old;
      if (whole) fb[0] = nv;
      else add_free(0, old, atlas_w, nv);
    end
    widen_next = !widen_next;
    return 1;
  endfunction

  function automatic bit best_area_slot(int unsigned w, h, output int unsigned idx);
    int unsigned best, fw, fh;
    bit found;
    found = 0;
    best = 0;
    idx = 0;
    for (int unsigned i = 0; i < nfree; i++) begin
      fw = fr[i] - fl[i];
      fh = fb[i] - ft[i];
      if (fw >= w && fh >= h && (!found || fw * fh < best)) begin
        found = 1;
        best = fw * fh;
        idx = i;
      end
    end
    return found;
  endfunction

  function automatic bit carve_free(int unsigned i, rl, rt, rr, rb);
    int unsigned l, t, r, b;
    l = fl[i]; t = ft[i]; r = fr[i]; b = fb[i];
    if (!(rr > l && rl < r && rb > t && rt < b)) return 0;
    if (rr < r) add_free(rr, t, r, b);
    if (rl > l) add_free(l, t, rl, b);
    if (rb < b) add_free(l, rb, r, b);
    if (rt > t) add_free(l, t, r, rt);
    return 1;
  endfunction

  function automatic bit enclosed(int unsigned a, b);
    return fl[a] >= fl[b] && ft[a] >= ft[b] && fr[a] <= fr[b] && fb[a] <= fb[b];
  endfunction

  function automatic void prune_enclosed();
    int unsigned i, j;
    bit gone;
    i = 0;
    while (i < nfree) begin
      gone = 0;
      j = i + 1;
      while (j < nfree) begin
        if (enclosed(i, j)) begin
          drop_free(i);
          gone = 1;
          break;
        end
        if (enclosed(j, i)) drop_free(j);
        else j++;
      end
      if (!gone) i++;
    end
  endfunction

  function automatic void reopen_atlas();
    atlas_w = (sh_start_w > CMAX) ? CMAX : sh_start_w;
    atlas_h = (sh_start_h > CMAX) ? CMAX : sh_start_h;
    widen_next = 1;
    dropped = 0;
    nfree = 1;
    fl[0] = 0; ft[0] = 0; fr[0] = atlas_w; fb[0] = atlas_h;
  endfunction

  function automatic raa_pkg::out_t place_rect(raa_pkg::in_t it);
    raa_pkg::out_t o;
    int unsigned w, h, b, rl, rt, rr, rb, i, sr, sb;
    bit ok;
    w = it.req_width;
    h = it.req_height;
    o = '0;
    if (it.kind == raa_pkg::KIND_RESTART) begin
      reopen_atlas();
    end else begin
      ok = 1;
      while (!best_area_slot(w, h, b)) begin
        if (!enlarge_atlas()) begin
          ok = 0;
          break;
        end
      end
      if (ok) begin
        rl = fl[b]; rt = ft[b]; rr = rl + w; rb = rt + h;
        o.granted = 1'b1;
        o.pos_x = rl[FB-1:0];
        o.pos_y = rt[FB-1:0];
        if (sh_fast) begin
          fl[b] = rr;
          if ((fb[b] - ft[b]) > 2 * h || h >= (atlas_h >> 1)) begin
            sr = fr[b]; sb = fb[b];
            fb[b] = rb;
            add_free(rl, rb, sr, sb);
          end
        end else begin
          i = 0;
          while (i < nfree) begin
            if (carve_free(i, rl, rt, rr, rb)) drop_free(i);
            else i++;
          end
          prune_enclosed();
        end
      end
    end
    o.atlas_width = atlas_w[FB-1:0];
    o.atlas_height = atlas_h[FB-1:0];
    o.list_overflow = dropped;
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (placements_due.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        raa_pkg::out_t w;
        w = placements_due.pop_front();
        if (out_data.granted !== w.granted) begin
          $error("granted: expected %0d, got %0d", w.granted, out_data.granted); errors++;
        end
        if (out_data.pos_x !== w.pos_x) begin
          $error("pos_x: expected %0d, got %0d", w.pos_x, out_data.pos_x); errors++;
        end
        if (out_data.pos_y !== w.pos_y) begin
          $error("pos_y: expected %0d, got %0d", w.pos_y, out_data.pos_y); errors++;
        end
        if (out_data.atlas_width !== w.atlas_width) begin
          $error("atlas_width: expected %0d, got %0d", w.atlas_width, out_data.atlas_width);
          errors++;
        end
        if (out_data.atlas_height !== w.atlas_height) begin
          $error("atlas_height: expected %0d, got %0d", w.atlas_height, out_data.atlas_height);
          errors++;
        end
        if (out_data.list_overflow !== w.list_overflow) begin
          $error("list_overflow: expected %0d, got %0d", w.list_overflow, out_data.list_overflow);
          errors++;
        end
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    int hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [raa_pkg::CFG_IDX_BITS-1:0] idx,
                           input int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[FB-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      raa_pkg::CFG_START_W: sh_start_w = val[FB-1:0];
      raa_pkg::CFG_START_H: sh_start_h = val[FB-1:0];
      raa_pkg::CFG_LIMIT_W: sh_lim_w = val[FB-1:0];
      raa_pkg::CFG_LIMIT_H: sh_lim_h = val[FB-1:0];
      raa_pkg::CFG_FAST:    sh_fast = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // starts and ends at a falling edge; valid stays high into the next item
  task automatic offer(input raa_pkg::in_t it, input bit typed, input raa_pkg::out_t want);
    raa_pkg::out_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    got = place_rect(it);
    placements_due.insert(placements_due.size(), typed ? want : got);
    n_items++;
    if (it.kind == raa_pkg::KIND_RESTART) n_restarts++;
    else if (got.granted) n_granted++;
    else n_refused++;
    if (got.list_overflow) n_overflow++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (placements_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic raa_pkg::in_t pick_item(int unsigned maxsz, int unsigned restart_pct);
    raa_pkg::in_t it;
    int unsigned r;
    it.kind = ($urandom_range(99) < restart_pct) ? raa_pkg::KIND_RESTART
                                                 : raa_pkg::KIND_ALLOC;
    r = $urandom_range(99);
    it.req_width = (r < 4) ? 13'd0 : (r < 8) ? 13'($urandom) : 13'($urandom_range(maxsz, 1));
    r = $urandom_range(99);
    it.req_height = (r < 4) ? 13'd0 : (r < 8) ? 13'($urandom) : 13'($urandom_range(maxsz, 1));
    return it;
  endfunction

  typedef struct {
    raa_pkg::in_t it;
    bit typed;
    raa_pkg::out_t want;
  } row_t;

  function automatic row_t mk(logic k, int unsigned w, h, bit typed = 0,
                              raa_pkg::out_t want = '0);
    row_t r;
    r.it.kind = k;
    r.it.req_width = w[FB-1:0];
    r.it.req_height = h[FB-1:0];
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // phase settings: start w/h, limit w/h, fast, items, max size, restart %, idle regime
  typedef struct {
    int unsigned sw, sh, lw, lh, fast, n, maxsz, rpct, regime;
  } phase_t;

  initial begin
    row_t dir[$];
    phase_t ph[$];
    raa_pkg::in_t it;
    row_t rs;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sh_start_w = raa_pkg::START_W_RST; sh_start_h = raa_pkg::START_H_RST;
    sh_lim_w = raa_pkg::LIMIT_W_RST; sh_lim_h = raa_pkg::LIMIT_H_RST;
    sh_fast = 0;
    for (int i = 0; i < NFREE; i++) begin
      fl[i] = 0; ft[i] = 0; fr[i] = 0; fb[i] = 0;
    end
    reopen_atlas();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // defaults: 256x256, limits 1024, full split
    dir.insert(dir.size(), mk(raa_pkg::KIND_RESTART, 0, 0, 1, '{0, 0, 0, 256, 256, 0}));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 0, 0, 1, '{1, 0, 0, 256, 256, 0}));
    // too big: grows to both limits, then refused with the growth kept
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 8191, 8191, 1, '{0, 0, 0, 1024, 1024, 0}));
    dir.insert(dir.size(), mk(raa_pkg::KIND_RESTART, 8191, 8191, 1, '{0, 0, 0, 256, 256, 0}));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 256, 256, 1, '{1, 0, 0, 256, 256, 0}));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 1, 1));  // empty list: growth adds a strip
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 300, 10));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 0, 40));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 40, 0));
    dir.insert(dir.size(), mk(raa_pkg::KIND_RESTART, 0, 0));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 100, 50));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 50, 100));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 100, 50));  // equal areas: earliest wins
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 4096, 1));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 1, 4096));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 7, 7));
    dir.insert(dir.size(), mk(raa_pkg::KIND_ALLOC, 1024, 1024));
    send_idle_pct = 28;
    recv_idle_pct = 74;
    foreach (dir[i]) offer(dir[i].it, dir[i].typed, dir[i].want);
    drain();

    ph.insert(ph.size(), phase_t'{256, 256, 1024, 1024, 0, 45, 40, 5, 0});
    ph.insert(ph.size(), phase_t'{64, 64, 4096, 4096, 1, 70, 24, 0, 0});  // fast split fills
    ph.insert(ph.size(), phase_t'{0, 0, 0, 0, 0, 12, 4, 10, 1});          // zero atlas
    ph.insert(ph.size(), phase_t'{8191, 8191, 8191, 8191, 1, 20, 4000, 5, 1});
    ph.insert(ph.size(), phase_t'{100, 30, 1600, 8191, 0, 60, 30, 4, 2});
    foreach (ph[p]) begin
      write_reg(raa_pkg::CFG_START_W, ph[p].sw);
      write_reg(raa_pkg::CFG_START_H, ph[p].sh);
      write_reg(raa_pkg::CFG_LIMIT_W, ph[p].lw);
      write_reg(raa_pkg::CFG_LIMIT_H, ph[p].lh);
      write_reg(raa_pkg::CFG_FAST, ph[p].fast);
      send_idle_pct = (ph[p].regime == 0) ? 28 : (ph[p].regime == 1) ? 74 : 0;
      recv_idle_pct = (ph[p].regime == 0) ? 74 : (ph[p].regime == 1) ? 28 : 0;
      rs = mk(raa_pkg::KIND_RESTART, 0, 0);
      offer(rs.it, 0, '0);
      if (p == 1) hold_trigger = 1;   // long receiver hold while items keep coming
      for (int i = 0; i < ph[p].n; i++) begin
        it = pick_item(ph[p].maxsz, ph[p].rpct);
        offer(it, 0, '0);
      end
      drain();
    end

    $display("ran %0d transactions: %0d restarts, %0d placed, %0d refused", n_items,
             n_restarts, n_granted, n_refused);
    $display("modes: full and guillotine split, zero and maximum atlas; %0d overflow results",
             n_overflow);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
